### sv/rtc3w_pkg.sv
// shared types and constants for the three-wire rtc serial master
// used by rtc3w_cfg, rtc3w_core and three_wire_rtc_serial_master_unit
package rtc3w_pkg;

	// configuration port geometry
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// register indexes (byte address is 4 * index)
	localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] REG_TURNAROUND  = 2'd1;
	localparam logic [1:0] REG_CONTROL     = 2'd2;

	// reset values of the registers
	localparam logic [7:0] HALF_PERIOD_RST = 8'd2;
	localparam logic [7:0] TURNAROUND_RST  = 8'd5;
	localparam logic [7:0] CONTROL_RST     = 8'd142;

	// command codes
	localparam logic [1:0] ACT_TICK      = 2'd0;
	localparam logic [1:0] ACT_WRITE     = 2'd1;
	localparam logic [1:0] ACT_READ      = 2'd2;
	localparam logic [1:0] ACT_PROTECTED = 2'd3;

	// protected write framing
	localparam logic [1:0] SUB_NONE       = 2'd0;
	localparam logic [1:0] SUB_UNPROTECT  = 2'd1;
	localparam logic [1:0] SUB_USER       = 2'd2;
	localparam logic [1:0] SUB_PROTECT    = 2'd3;
	localparam logic [7:0] CTRL_OPEN      = 8'h00;
	localparam logic [7:0] CTRL_CLOSE     = 8'h80;
	localparam logic [7:0] READ_FLAG      = 8'h01;

	// bit positions in a frame
	localparam logic [3:0] BIT_FIRST      = 4'd0;
	localparam logic [3:0] BIT_ADDR_LAST  = 4'd7;
	localparam logic [3:0] BIT_DATA_FIRST = 4'd8;
	localparam logic [3:0] BIT_DATA_LAST  = 4'd15;

	// pin sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_SET_DATA  = 4'd1,
		PH_CLK_HIGH  = 4'd2,
		PH_BYTE2     = 4'd3,
		PH_FALL_LAST = 4'd4,
		PH_RELEASE   = 4'd5,
		PH_SAMPLE    = 4'd6,
		PH_READ_LOW  = 4'd7,
		PH_END       = 4'd8,
		PH_START     = 4'd9
	} phase_t;

	typedef struct packed {
		logic [7:0] half_period_ticks;
		logic [7:0] turnaround_ticks;
		logic [7:0] control_address;
	} cfg_t;

	typedef struct packed {
		logic chip_enable;
		logic serial_clock;
		logic line_out;
		logic line_drive;
	} pins_t;

	typedef struct packed {
		logic       rejected;
		logic       busy_res;
		logic       finished;
		logic [7:0] read_value;
		logic       line_drive;
		logic       line_out;
		logic       serial_clock;
		logic       chip_enable;
	} res_t;

	// a programmed delay of zero behaves as one tick
	function automatic logic [7:0] hold_for(input logic [7:0] t);
		hold_for = (t == 8'd0) ? 8'd0 : t - 8'd1;
	endfunction

endpackage

### sv/rtc3w_cfg.sv
// apb-style register file: half period, turnaround and control address
// depends on rtc3w_pkg
module rtc3w_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rtc3w_pkg::ADDR_W-1:0] paddr,
	input  logic [rtc3w_pkg::DATA_W-1:0] pwdata,
	output logic [rtc3w_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output rtc3w_pkg::cfg_t             cfg
);

	rtc3w_pkg::cfg_t cfg_q;
	logic [1:0]      index;
	logic            wr_en;

	assign pready = 1'b1;
	assign index  = paddr[rtc3w_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= rtc3w_pkg::HALF_PERIOD_RST;
			cfg_q.turnaround_ticks  <= rtc3w_pkg::TURNAROUND_RST;
			cfg_q.control_address   <= rtc3w_pkg::CONTROL_RST;
		end else if (wr_en) begin
			case (index)
				rtc3w_pkg::REG_HALF_PERIOD: cfg_q.half_period_ticks <= pwdata[7:0];
				rtc3w_pkg::REG_TURNAROUND:  cfg_q.turnaround_ticks  <= pwdata[7:0];
				rtc3w_pkg::REG_CONTROL:     cfg_q.control_address   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read-back
	always_comb begin
		case (index)
			rtc3w_pkg::REG_HALF_PERIOD: prdata = {24'd0, cfg_q.half_period_ticks};
			rtc3w_pkg::REG_TURNAROUND:  prdata = {24'd0, cfg_q.turnaround_ticks};
			rtc3w_pkg::REG_CONTROL:     prdata = {24'd0, cfg_q.control_address};
			default:                    prdata = '0;
		endcase
	end

endmodule

### sv/rtc3w_core.sv
// pin sequencer: one tick or command per step, state held in registers
// depends on rtc3w_pkg
module rtc3w_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [1:0]      action,
	input  logic [7:0]      reg_address,
	input  logic [7:0]      write_value,
	input  logic            line_in,
	input  rtc3w_pkg::cfg_t cfg,
	output rtc3w_pkg::res_t res
);

	rtc3w_pkg::phase_t phase_q, phase_d;
	logic [3:0]        bit_q, bit_d;
	logic [7:0]        wait_q, wait_d;
	logic [7:0]        sout_q, sout_d;
	logic [7:0]        sin_q, sin_d;
	logic [7:0]        addr_q, addr_d;
	logic [7:0]        value_q, value_d;
	logic [1:0]        sub_q, sub_d;
	logic              is_read_q, is_read_d;
	rtc3w_pkg::pins_t  pins_q, pins_d;
	logic [7:0]        last_q, last_d;
	logic              done;
	logic              rej;
	logic [7:0]        hold_half;

	assign hold_half = rtc3w_pkg::hold_for(cfg.half_period_ticks);

	// next state for one step
	always_comb begin
		phase_d   = phase_q;
		bit_d     = bit_q;
		wait_d    = wait_q;
		sout_d    = sout_q;
		sin_d     = sin_q;
		addr_d    = addr_q;
		value_d   = value_q;
		sub_d     = sub_q;
		is_read_d = is_read_q;
		pins_d    = pins_q;
		last_d    = last_q;
		done      = 1'b0;
		rej       = 1'b0;
		if (phase_q == rtc3w_pkg::PH_IDLE) begin
			if (action != rtc3w_pkg::ACT_TICK) begin
				addr_d    = reg_address;
				value_d   = write_value;
				is_read_d = (action == rtc3w_pkg::ACT_READ);
				sub_d     = (action == rtc3w_pkg::ACT_PROTECTED) ?
					rtc3w_pkg::SUB_UNPROTECT : rtc3w_pkg::SUB_NONE;
				if (action == rtc3w_pkg::ACT_READ)
					sout_d = reg_address | rtc3w_pkg::READ_FLAG;
				else if (action == rtc3w_pkg::ACT_PROTECTED)
					sout_d = cfg.control_address;
				else
					sout_d = reg_address;
				pins_d.chip_enable  = 1'b1;
				pins_d.line_drive   = 1'b1;
				pins_d.serial_clock = 1'b0;
				bit_d   = rtc3w_pkg::BIT_FIRST;
				wait_d  = hold_half;
				phase_d = rtc3w_pkg::PH_SET_DATA;
			end
		end else begin
			rej = (action != rtc3w_pkg::ACT_TICK);
			if (wait_q != 8'd0) begin
				wait_d = wait_q - 8'd1;
			end else begin
				case (phase_q)
					rtc3w_pkg::PH_SET_DATA: begin
						pins_d.line_out     = sout_q[0];
						pins_d.serial_clock = 1'b0;
						sout_d  = {1'b0, sout_q[7:1]};
						wait_d  = hold_half;
						phase_d = rtc3w_pkg::PH_CLK_HIGH;
					end
					rtc3w_pkg::PH_CLK_HIGH: begin
						pins_d.serial_clock = 1'b1;
						wait_d = hold_half;
						if (bit_q == rtc3w_pkg::BIT_DATA_LAST) begin
							phase_d = rtc3w_pkg::PH_FALL_LAST;
						end else if (bit_q == rtc3w_pkg::BIT_ADDR_LAST) begin
							phase_d = is_read_q ? rtc3w_pkg::PH_RELEASE : rtc3w_pkg::PH_BYTE2;
						end else begin
							bit_d   = bit_q + 4'd1;
							phase_d = rtc3w_pkg::PH_SET_DATA;
						end
					end
					rtc3w_pkg::PH_BYTE2: begin
						if (sub_q == rtc3w_pkg::SUB_UNPROTECT)
							sout_d = rtc3w_pkg::CTRL_OPEN;
						else if (sub_q == rtc3w_pkg::SUB_PROTECT)
							sout_d = rtc3w_pkg::CTRL_CLOSE;
						else
							sout_d = value_q;
						pins_d.line_drive   = 1'b1;
						pins_d.serial_clock = 1'b0;
						bit_d   = rtc3w_pkg::BIT_DATA_FIRST;
						wait_d  = hold_half;
						phase_d = rtc3w_pkg::PH_SET_DATA;
					end
					rtc3w_pkg::PH_FALL_LAST: begin
						pins_d.serial_clock = 1'b0;
						wait_d  = 8'd0;
						phase_d = rtc3w_pkg::PH_END;
					end
					rtc3w_pkg::PH_RELEASE: begin
						pins_d.serial_clock = 1'b0;
						pins_d.line_drive   = 1'b0;
						bit_d   = rtc3w_pkg::BIT_FIRST;
						wait_d  = rtc3w_pkg::hold_for(cfg.turnaround_ticks);
						phase_d = rtc3w_pkg::PH_SAMPLE;
					end
					rtc3w_pkg::PH_SAMPLE: begin
						sin_d = {line_in, sin_q[7:1]};
						pins_d.serial_clock = 1'b1;
						wait_d  = hold_half;
						phase_d = rtc3w_pkg::PH_READ_LOW;
					end
					rtc3w_pkg::PH_READ_LOW: begin
						pins_d.serial_clock = 1'b0;
						wait_d = hold_half;
						if (bit_q >= rtc3w_pkg::BIT_ADDR_LAST) begin
							phase_d = rtc3w_pkg::PH_END;
						end else begin
							bit_d   = bit_q + 4'd1;
							phase_d = rtc3w_pkg::PH_SAMPLE;
						end
					end
					rtc3w_pkg::PH_END: begin
						pins_d.serial_clock = 1'b1;
						pins_d.chip_enable  = 1'b0;
						wait_d = 8'd0;
						if (is_read_q)
							last_d = sin_q;
						if (!is_read_q && (sub_q inside {rtc3w_pkg::SUB_UNPROTECT,
							rtc3w_pkg::SUB_USER})) begin
							sub_d   = sub_q + 2'd1;
							phase_d = rtc3w_pkg::PH_START;
						end else begin
							sub_d   = rtc3w_pkg::SUB_NONE;
							phase_d = rtc3w_pkg::PH_IDLE;
							done    = 1'b1;
						end
					end
					rtc3w_pkg::PH_START: begin
						// next frame of a protected write
						if (is_read_q)
							sout_d = addr_q | rtc3w_pkg::READ_FLAG;
						else if (sub_q inside {rtc3w_pkg::SUB_UNPROTECT,
							rtc3w_pkg::SUB_PROTECT})
							sout_d = cfg.control_address;
						else
							sout_d = addr_q;
						pins_d.chip_enable  = 1'b1;
						pins_d.line_drive   = 1'b1;
						pins_d.serial_clock = 1'b0;
						bit_d   = rtc3w_pkg::BIT_FIRST;
						wait_d  = hold_half;
						phase_d = rtc3w_pkg::PH_SET_DATA;
					end
					default: begin
						phase_d = rtc3w_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	// result fields as seen after this step
	always_comb begin
		res.chip_enable  = pins_d.chip_enable;
		res.serial_clock = pins_d.serial_clock;
		res.line_out     = pins_d.line_out;
		res.line_drive   = pins_d.line_drive;
		res.read_value   = last_d;
		res.finished     = done;
		res.busy_res     = (phase_d != rtc3w_pkg::PH_IDLE);
		res.rejected     = rej;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rtc3w_pkg::PH_IDLE;
			bit_q     <= '0;
			wait_q    <= '0;
			sub_q     <= rtc3w_pkg::SUB_NONE;
			is_read_q <= 1'b0;
			pins_q    <= '0;
			last_q    <= '0;
			sout_q    <= '0;
			sin_q     <= '0;
			addr_q    <= '0;
			value_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			bit_q     <= bit_d;
			wait_q    <= wait_d;
			sub_q     <= sub_d;
			is_read_q <= is_read_d;
			pins_q    <= pins_d;
			last_q    <= last_d;
			sout_q    <= sout_d;
			sin_q     <= sin_d;
			addr_q    <= addr_d;
			value_q   <= value_d;
		end
	end

	// a tick while idle leaves the sequencer idle
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == rtc3w_pkg::PH_IDLE && action == rtc3w_pkg::ACT_TICK
		|=> phase_q == rtc3w_pkg::PH_IDLE)
		else $error("idle tick started a transaction");

	// a running delay holds the phase
	a_wait_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q != rtc3w_pkg::PH_IDLE && wait_q != 8'd0
		|=> phase_q == $past(phase_q))
		else $error("phase moved during a delay");

	// protected framing never applies to a read
	a_sub_write_only: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q != rtc3w_pkg::SUB_NONE |-> !is_read_q)
		else $error("protected framing on a read");

	// the data line is released while bits are shifted in
	a_release_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == rtc3w_pkg::PH_SAMPLE || phase_q == rtc3w_pkg::PH_READ_LOW)
		|-> !pins_q.line_drive)
		else $error("data line driven while reading");

endmodule

### sv/three_wire_rtc_serial_master_unit.sv
// top level of the three-wire rtc serial master: input stage, sequencer, result stage
// depends on rtc3w_pkg, rtc3w_cfg and rtc3w_core
//
// usage
//   s_* carries one request per time step: a tick or a command (write, read,
//   protected write) in tuser, with address, data byte and sampled data line
//   in tdata. m_* returns exactly one result per request: the pin levels
//   after that step, the last read byte and the finished, busy and rejected
//   flags. the apb port sets the half period, turnaround and control
//   address; write it only while no request is in flight.
// pipeline and throughput
//   an accepted request is held in the input register, processed by the
//   sequencer when it advances and shown from the result register: m_tvalid
//   rises once the result is stored there. one request per cycle is
//   sustained while m_tready stays high; the rate is set by the single
//   sequencer step between the two registers.
// reset
//   arst_n clears both stages, the sequencer (idle, pins low, line released,
//   read byte zero) and restores the register reset values.
// stalls
//   while m_tready is low the result is held and one more request waits in
//   the input register; s_tready falls only when both are occupied.
module three_wire_rtc_serial_master_unit (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // reg_address[7:0], write_value[15:8], line_in[16], zero[23:17]
	input  logic [1:0]  s_tuser,   // action[1:0]
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // chip_enable[0], serial_clock[1], line_out[2], line_drive[3],
	                               // read_value[11:4], finished[12], busy_res[13], rejected[14],
	                               // zero[15]
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rtc3w_pkg::ADDR_W-1:0] paddr,
	input  logic [rtc3w_pkg::DATA_W-1:0] pwdata,
	output logic [rtc3w_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	rtc3w_pkg::cfg_t cfg;
	rtc3w_pkg::res_t res;
	rtc3w_pkg::res_t res_s2;
	logic            valid_s1;
	logic [1:0]      action_s1;
	logic [7:0]      addr_s1;
	logic [7:0]      value_s1;
	logic            line_s1;
	logic            valid_s2;
	logic            adv_s1;
	logic            ready_s1;

	rtc3w_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake between the stages
	assign ready_s1 = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && ready_s1;
	assign s_tready = !valid_s1 || ready_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			addr_s1   <= s_tdata[7:0];
			value_s1  <= s_tdata[15:8];
			line_s1   <= s_tdata[16];
		end
	end

	rtc3w_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv_s1),
		.action      (action_s1),
		.reg_address (addr_s1),
		.write_value (value_s1),
		.line_in     (line_s1),
		.cfg         (cfg),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2};

endmodule
